[design/rrts_pkg.sv]
// Package with types, codes and constants for the round-robin task scheduler.
`default_nettype none
package rrts_pkg;

  localparam int NUM_TASKS = 16;
  localparam int TID_W = 4;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);
  localparam int ST_W = 3;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_SCHEDULE = 3'd1;
  localparam logic [2:0] OP_BLOCK = 3'd2;
  localparam logic [2:0] OP_UNBLOCK = 3'd3;
  localparam logic [2:0] OP_YIELD = 3'd4;
  localparam logic [2:0] OP_EXIT = 3'd5;

  localparam logic [ST_W-1:0] ST_RUNNING = 3'd0;
  localparam logic [ST_W-1:0] ST_READY = 3'd1;
  localparam logic [ST_W-1:0] ST_BLOCKED = 3'd2;
  localparam logic [ST_W-1:0] ST_WAITING = 3'd3;
  localparam logic [ST_W-1:0] ST_HANGING = 3'd4;
  localparam logic [ST_W-1:0] ST_DEAD = 3'd5;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_BAD = 2'd1;
  localparam logic [1:0] ERR_NORUN = 2'd2;

  localparam logic [1:0] KIND_MAX = 2'd2;

  typedef struct packed {
    logic [2:0]       operation;
    logic [TID_W-1:0] task_id;
    logic [1:0]       block_kind;
    logic             reschedule;
    logic             start_running;
  } req_t;

  typedef struct packed {
    logic [TID_W-1:0] running_task;
    logic             switched;
    logic [1:0]       error;
  } res_t;

  typedef enum logic [1:0] {
    SEL_T,
    SEL_CUR,
    SEL_IDLE,
    SEL_HEAD
  } sel_e;

  typedef enum logic [1:0] {
    WD_READY,
    WD_RUNNING,
    WD_DEAD,
    WD_KIND
  } wd_e;

  typedef struct packed {
    logic latch;
    sel_e sel;
    logic st_wr;
    wd_e  wd;
    logic append;
    logic push;
    logic unlink;
    logic pop;
    logic set_cur;
    logic err_bad;
    logic err_norun;
    logic res_valid;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0]      op;
    logic [ST_W-1:0] st;
    logic            start_running;
    logic            reschedule;
    logic            kind_ok;
    logic            tid_ok;
    logic            cnt_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

[design/round_robin_task_scheduler.sv]
// Top level of the round-robin task scheduler.
// An item is taken when start is high and busy is low; its result strobes on
// res_valid_o at the end of the controller's walk over the status and link
// RAMs (one registered read per step). A new item is taken the cycle after
// the strobe. The receiver cannot stall. Reset marks every slot dead, clears
// queue, current task and idle task, and needs no clearing pass.
`default_nettype none
module round_robin_task_scheduler
  import rrts_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             req_i,
  output logic                  res_valid_o,
  output res_t                  res_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [TID_W-1:0] cfg_data_i
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;
  assign res_valid_o = cmd.res_valid;

  rrts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  rrts_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_o      (res_o)
  );

endmodule
`default_nettype wire

[design/rrts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rrts_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[design/rrts_dp.sv]
// Datapath of the task scheduler: status and link memories, queue registers, result.
`default_nettype none
module rrts_dp
  import rrts_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire req_t       req_i,
  input  wire logic       cfg_we_i,
  input  wire logic [TID_W-1:0] cfg_data_i,
  input  wire ctl_cmd_t   cmd_i,
  output dp_stat_t        stat_o,
  output res_t            res_o
);

  req_t             req_q;
  logic [TID_W-1:0] cur_q, cur_d;
  logic [TID_W-1:0] head_q, head_d;
  logic [TID_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [TID_W-1:0] idle_q;
  logic [1:0]       err_q;
  logic             sw_q;
  logic [NUM_TASKS-1:0] stv_q;
  logic             stv_rd_q;

  logic [TID_W-1:0] idx;
  logic [ST_W-1:0]  st_wdata;
  logic [ST_W-1:0]  st_rd;
  logic [TID_W-1:0] nxt_rd;
  logic [TID_W-1:0] prv_rd;
  logic             nxt_we, prv_we;
  logic [TID_W-1:0] nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
  logic             cnt_zero, cnt_one, ul_mid;

  always_comb begin
    case (cmd_i.sel)
      SEL_T:    idx = req_q.task_id;
      SEL_CUR:  idx = cur_q;
      SEL_IDLE: idx = idle_q;
      SEL_HEAD: idx = head_q;
      default:  idx = req_q.task_id;
    endcase
  end

  always_comb begin
    case (cmd_i.wd)
      WD_READY:   st_wdata = ST_READY;
      WD_RUNNING: st_wdata = ST_RUNNING;
      WD_DEAD:    st_wdata = ST_DEAD;
      WD_KIND:    st_wdata = ST_BLOCKED + {1'b0, req_q.block_kind};
      default:    st_wdata = ST_DEAD;
    endcase
  end

  assign cnt_zero = (cnt_q == '0);
  assign cnt_one  = (cnt_q == CNT_W'(1));
  assign ul_mid   = !cnt_zero && !cnt_one && (idx != head_q) && (idx != tail_q);

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = tail_q;
    nxt_wdata = idx;
    prv_we    = 1'b0;
    prv_waddr = idx;
    prv_wdata = tail_q;
    if (cmd_i.append && !cnt_zero) begin
      nxt_we    = 1'b1;
      nxt_waddr = tail_q;
      nxt_wdata = idx;
      prv_we    = 1'b1;
      prv_waddr = idx;
      prv_wdata = tail_q;
    end else if (cmd_i.push && !cnt_zero) begin
      nxt_we    = 1'b1;
      nxt_waddr = idx;
      nxt_wdata = head_q;
      prv_we    = 1'b1;
      prv_waddr = head_q;
      prv_wdata = idx;
    end else if (cmd_i.unlink && ul_mid) begin
      nxt_we    = 1'b1;
      nxt_waddr = prv_rd;
      nxt_wdata = nxt_rd;
      prv_we    = 1'b1;
      prv_waddr = nxt_rd;
      prv_wdata = prv_rd;
    end
  end

  rrts_ram #(.W(ST_W), .D(NUM_TASKS)) u_status (
    .clk_i   (clk_i),
    .we_i    (cmd_i.st_wr),
    .waddr_i (idx),
    .wdata_i (st_wdata),
    .raddr_i (idx),
    .rdata_o (st_rd)
  );

  rrts_ram #(.W(TID_W), .D(NUM_TASKS)) u_next (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (idx),
    .rdata_o (nxt_rd)
  );

  rrts_ram #(.W(TID_W), .D(NUM_TASKS)) u_prev (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (idx),
    .rdata_o (prv_rd)
  );

  always_comb begin
    cur_d  = cur_q;
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (cmd_i.set_cur) begin
      cur_d = idx;
    end
    if (cmd_i.append) begin
      if (cnt_zero) begin
        head_d = idx;
      end
      tail_d = idx;
      cnt_d  = cnt_q + CNT_W'(1);
    end else if (cmd_i.push) begin
      if (cnt_zero) begin
        tail_d = idx;
      end
      head_d = idx;
      cnt_d  = cnt_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (!cnt_one) begin
        head_d = nxt_rd;
      end
    end else if (cmd_i.unlink && !cnt_zero) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (!cnt_one) begin
        if (idx == head_q) begin
          head_d = nxt_rd;
        end else if (idx == tail_q) begin
          tail_d = prv_rd;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      idle_q   <= '0;
      stv_q    <= '0;
      stv_rd_q <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      stv_rd_q <= stv_q[idx];
      if (cmd_i.st_wr) begin
        stv_q[idx] <= 1'b1;
      end
      if (cfg_we_i) begin
        idle_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
      err_q <= ERR_OK;
      sw_q  <= 1'b0;
    end else begin
      if (cmd_i.err_bad) begin
        err_q <= ERR_BAD;
      end else if (cmd_i.err_norun) begin
        err_q <= ERR_NORUN;
      end
      if (cmd_i.pop) begin
        sw_q <= 1'b1;
      end
    end
  end

  always_comb begin
    stat_o.op            = req_q.operation;
    stat_o.st            = stv_rd_q ? st_rd : ST_DEAD;
    stat_o.start_running = req_q.start_running;
    stat_o.reschedule    = req_q.reschedule;
    stat_o.kind_ok       = (req_q.block_kind <= KIND_MAX);
    stat_o.tid_ok        = (32'(req_q.task_id) < NUM_TASKS);
    stat_o.cnt_zero      = cnt_zero;
  end

  assign res_o.running_task = cur_q;
  assign res_o.switched     = sw_q;
  assign res_o.error        = err_q;

endmodule
`default_nettype wire

[design/rrts_ctrl.sv]
// Controller state machine that sequences each scheduler operation over the datapath.
`default_nettype none
module rrts_ctrl
  import rrts_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat_i,
  output ctl_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_CHK      = 4'd2;
  localparam logic [3:0] S_CR_CHK   = 4'd3;
  localparam logic [3:0] S_UNLINK   = 4'd4;
  localparam logic [3:0] S_SCH      = 4'd5;
  localparam logic [3:0] S_SCH_CHK  = 4'd6;
  localparam logic [3:0] S_SCH_Q    = 4'd7;
  localparam logic [3:0] S_IDLE_CHK = 4'd8;
  localparam logic [3:0] S_POP_RD   = 4'd9;
  localparam logic [3:0] S_POP      = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state_q, state_d;
  logic       st_blk;

  assign st_blk = (stat_i.st == ST_BLOCKED) || (stat_i.st == ST_WAITING) ||
                  (stat_i.st == ST_HANGING);
  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = SEL_T;
    cmd_o.wd  = WD_READY;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        case (stat_i.op)
          OP_CREATE, OP_UNBLOCK, OP_EXIT: begin
            cmd_o.sel = SEL_T;
            state_d = S_CHK;
          end
          OP_SCHEDULE: begin
            cmd_o.sel = SEL_CUR;
            state_d = S_SCH_CHK;
          end
          OP_BLOCK: begin
            cmd_o.sel = SEL_CUR;
            if (stat_i.kind_ok) begin
              state_d = S_CHK;
            end else begin
              cmd_o.err_bad = 1'b1;
              state_d = S_DONE;
            end
          end
          OP_YIELD: begin
            cmd_o.sel = SEL_CUR;
            state_d = S_CHK;
          end
          default: begin
            cmd_o.err_bad = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_CHK: begin
        state_d = S_DONE;
        case (stat_i.op)
          OP_CREATE: begin
            if (!stat_i.tid_ok || stat_i.st != ST_DEAD) begin
              cmd_o.err_bad = 1'b1;
            end else if (stat_i.start_running) begin
              cmd_o.sel = SEL_CUR;
              state_d = S_CR_CHK;
            end else begin
              cmd_o.sel    = SEL_T;
              cmd_o.st_wr  = 1'b1;
              cmd_o.wd     = WD_READY;
              cmd_o.append = 1'b1;
            end
          end
          OP_BLOCK: begin
            cmd_o.sel = SEL_CUR;
            if (stat_i.st != ST_RUNNING) begin
              cmd_o.err_bad = 1'b1;
            end else begin
              cmd_o.st_wr = 1'b1;
              cmd_o.wd    = WD_KIND;
              state_d = S_SCH;
            end
          end
          OP_UNBLOCK: begin
            cmd_o.sel = SEL_T;
            if (!stat_i.tid_ok) begin
              cmd_o.err_bad = 1'b1;
            end else if (st_blk) begin
              cmd_o.st_wr = 1'b1;
              cmd_o.wd    = WD_READY;
              cmd_o.push  = 1'b1;
            end else if (stat_i.st != ST_READY) begin
              cmd_o.err_bad = 1'b1;
            end
          end
          OP_YIELD: begin
            cmd_o.sel = SEL_CUR;
            if (stat_i.st != ST_RUNNING) begin
              cmd_o.err_bad = 1'b1;
            end else begin
              cmd_o.st_wr  = 1'b1;
              cmd_o.wd     = WD_READY;
              cmd_o.append = 1'b1;
              state_d = S_SCH;
            end
          end
          OP_EXIT: begin
            cmd_o.sel = SEL_T;
            if (!stat_i.tid_ok || stat_i.st == ST_DEAD) begin
              cmd_o.err_bad = 1'b1;
            end else if (stat_i.st == ST_READY) begin
              state_d = S_UNLINK;
            end else begin
              cmd_o.st_wr = 1'b1;
              cmd_o.wd    = WD_DEAD;
              state_d = stat_i.reschedule ? S_SCH : S_DONE;
            end
          end
          default: begin
            cmd_o.err_bad = 1'b1;
          end
        endcase
      end
      S_CR_CHK: begin
        state_d = S_DONE;
        cmd_o.sel = SEL_T;
        if (stat_i.st == ST_RUNNING) begin
          cmd_o.err_bad = 1'b1;
        end else begin
          cmd_o.st_wr   = 1'b1;
          cmd_o.wd      = WD_RUNNING;
          cmd_o.set_cur = 1'b1;
        end
      end
      S_UNLINK: begin
        cmd_o.sel    = SEL_T;
        cmd_o.unlink = 1'b1;
        cmd_o.st_wr  = 1'b1;
        cmd_o.wd     = WD_DEAD;
        state_d = stat_i.reschedule ? S_SCH : S_DONE;
      end
      S_SCH: begin
        cmd_o.sel = SEL_CUR;
        state_d = S_SCH_CHK;
      end
      S_SCH_CHK: begin
        cmd_o.sel = SEL_CUR;
        if (stat_i.st == ST_RUNNING) begin
          cmd_o.st_wr  = 1'b1;
          cmd_o.wd     = WD_READY;
          cmd_o.append = 1'b1;
        end
        state_d = S_SCH_Q;
      end
      S_SCH_Q: begin
        if (stat_i.cnt_zero) begin
          cmd_o.sel = SEL_IDLE;
          state_d = S_IDLE_CHK;
        end else begin
          cmd_o.sel = SEL_HEAD;
          state_d = S_POP;
        end
      end
      S_IDLE_CHK: begin
        cmd_o.sel = SEL_IDLE;
        if (st_blk) begin
          cmd_o.st_wr = 1'b1;
          cmd_o.wd    = WD_READY;
          cmd_o.push  = 1'b1;
          state_d = S_POP_RD;
        end else begin
          cmd_o.err_norun = 1'b1;
          state_d = S_DONE;
        end
      end
      S_POP_RD: begin
        cmd_o.sel = SEL_HEAD;
        state_d = S_POP;
      end
      S_POP: begin
        cmd_o.sel     = SEL_HEAD;
        cmd_o.st_wr   = 1'b1;
        cmd_o.wd      = WD_RUNNING;
        cmd_o.set_cur = 1'b1;
        cmd_o.pop     = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.res_valid = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the round-robin task scheduler with its own ready-queue predictor.
module tb;
  import rrts_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [1:0] KIND_BLOCKED = 2'd0;
  localparam logic [1:0] KIND_WAITING = 2'd1;
  localparam logic [1:0] KIND_HANGING = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 340;

  typedef enum int {WANT_DEAD, WANT_PARKED, WANT_LIVE} want_e;

  class sched_scoreboard;
    logic [ST_W-1:0]  status [NUM_TASKS];
    logic [TID_W-1:0] next_of [NUM_TASKS];
    logic [TID_W-1:0] prev_of [NUM_TASKS];
    bit               next_known [NUM_TASKS];
    bit               prev_known [NUM_TASKS];
    logic [TID_W-1:0] head, tail, cur, idle;
    int unsigned      depth;
    res_t             expected_q [$];
    int unsigned      items, checked, switches, no_run, idle_writes, mismatches;

    function new();
      for (int i = 0; i < NUM_TASKS; i++) begin
        status[i] = ST_DEAD;
        next_of[i] = '0;
        prev_of[i] = '0;
        next_known[i] = 1'b0;
        prev_known[i] = 1'b0;
      end
      head = '0;
      tail = '0;
      cur = '0;
      idle = '0;
      depth = 0;
    endfunction

    function bit is_parked(logic [ST_W-1:0] s);
      return s == ST_BLOCKED || s == ST_WAITING || s == ST_HANGING;
    endfunction

    function void append(logic [TID_W-1:0] t);
      if (depth == 0) begin
        head = t;
      end else begin
        next_of[tail] = t;
        next_known[tail] = 1'b1;
        prev_of[t] = tail;
        prev_known[t] = 1'b1;
      end
      tail = t;
      depth++;
    endfunction

    function void push(logic [TID_W-1:0] t);
      if (depth == 0) begin
        tail = t;
      end else begin
        prev_of[head] = t;
        prev_known[head] = 1'b1;
        next_of[t] = head;
        next_known[t] = 1'b1;
      end
      head = t;
      depth++;
    endfunction

    function logic [TID_W-1:0] pop();
      logic [TID_W-1:0] t;
      t = head;
      depth--;
      if (depth != 0) head = next_of[t];
      return t;
    endfunction

    function void unlink(logic [TID_W-1:0] t);
      logic [TID_W-1:0] p, n;
      p = prev_of[t];
      n = next_of[t];
      if (depth == 0) return;
      if (depth == 1) begin
        depth = 0;
        return;
      end
      if (t == head) begin
        head = n;
      end else if (t == tail) begin
        tail = p;
      end else begin
        next_of[p] = n;
        prev_of[n] = p;
      end
      depth--;
    endfunction

    function logic [1:0] run_schedule(output bit sw);
      logic [TID_W-1:0] t;
      sw = 1'b0;
      if (status[cur] == ST_RUNNING) begin
        status[cur] = ST_READY;
        append(cur);
      end
      if (depth == 0 && is_parked(status[idle])) begin
        status[idle] = ST_READY;
        push(idle);
      end
      if (depth == 0) return ERR_NORUN;
      t = pop();
      status[t] = ST_RUNNING;
      cur = t;
      sw = 1'b1;
      return ERR_OK;
    endfunction

    function void note_item(req_t r);
      logic [1:0]       err;
      bit               sw;
      logic [TID_W-1:0] t;
      res_t             outcome;
      err = ERR_OK;
      sw = 1'b0;
      t = r.task_id;
      case (r.operation)
        OP_CREATE: begin
          if (status[t] != ST_DEAD) begin
            err = ERR_BAD;
          end else if (r.start_running) begin
            if (status[cur] == ST_RUNNING) begin
              err = ERR_BAD;
            end else begin
              status[t] = ST_RUNNING;
              cur = t;
            end
          end else begin
            status[t] = ST_READY;
            append(t);
          end
        end
        OP_SCHEDULE: err = run_schedule(sw);
        OP_BLOCK: begin
          if (r.block_kind > KIND_MAX || status[cur] != ST_RUNNING) begin
            err = ERR_BAD;
          end else begin
            status[cur] = ST_BLOCKED + r.block_kind;
            err = run_schedule(sw);
          end
        end
        OP_UNBLOCK: begin
          if (is_parked(status[t])) begin
            status[t] = ST_READY;
            push(t);
          end else if (status[t] != ST_READY) begin
            err = ERR_BAD;
          end
        end
        OP_YIELD: begin
          if (status[cur] != ST_RUNNING) begin
            err = ERR_BAD;
          end else begin
            status[cur] = ST_READY;
            append(cur);
            err = run_schedule(sw);
          end
        end
        OP_EXIT: begin
          if (status[t] == ST_DEAD) begin
            err = ERR_BAD;
          end else begin
            if (status[t] == ST_READY) unlink(t);
            status[t] = ST_DEAD;
            if (r.reschedule) err = run_schedule(sw);
          end
        end
        default: err = ERR_BAD;
      endcase
      outcome.running_task = cur;
      outcome.switched = sw;
      outcome.error = err;
      expected_q.push_back(outcome);
      items++;
      if (sw) switches++;
      if (err == ERR_NORUN) no_run++;
    endfunction

    task report(string msg);
      // Printing is capped to keep a badly broken run readable.
      if (mismatches < 200) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result task=%0d switched=%0b error=%0d",
                         got.running_task, got.switched, got.error));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.running_task !== want.running_task)
        report($sformatf("result %0d running_task got %0d want %0d",
                         checked, got.running_task, want.running_task));
      if (got.switched !== want.switched)
        report($sformatf("result %0d switched got %0b want %0b",
                         checked, got.switched, want.switched));
      if (got.error !== want.error)
        report($sformatf("result %0d error got %0d want %0d",
                         checked, got.error, want.error));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req;
  logic             res_valid;
  res_t             res;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [TID_W-1:0] cfg_data;

  sched_scoreboard  sb;
  int               idle_pct;
  int               directed_items;
  int               gap_plan [PHASES] = '{0, 53, 0, 19, 53, 0};
  logic [TID_W-1:0] idle_plan [PHASES] = '{4'd15, 4'd0, 4'd9, 4'd15, 4'd0, 4'd5};

  round_robin_task_scheduler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (res_valid === 1'b1) sb.check_result(res);
  end

  function automatic req_t mk(logic [2:0] op, logic [TID_W-1:0] tid, logic [1:0] kind,
                              logic resched, logic run_now);
    req_t r;
    r.operation = op;
    r.task_id = tid;
    r.block_kind = kind;
    r.reschedule = resched;
    r.start_running = run_now;
    return r;
  endfunction

  function automatic logic [TID_W-1:0] pick_slot(want_e want);
    int unsigned      base;
    logic [TID_W-1:0] s;
    bit               hit;
    base = $urandom_range(0, NUM_TASKS - 1);
    for (int i = 0; i < NUM_TASKS; i++) begin
      s = TID_W'((base + i) % NUM_TASKS);
      case (want)
        WANT_DEAD:   hit = sb.status[s] == ST_DEAD;
        WANT_PARKED: hit = sb.is_parked(sb.status[s]);
        default:     hit = sb.status[s] != ST_DEAD;
      endcase
      if (hit) return s;
    end
    return TID_W'(base);
  endfunction

  function automatic req_t random_item();
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    r.task_id = TID_W'($urandom_range(0, NUM_TASKS - 1));
    r.block_kind = ($urandom_range(0, 19) == 0) ? KIND_BAD : 2'($urandom_range(0, 2));
    r.reschedule = 1'($urandom_range(0, 1));
    r.start_running = ($urandom_range(0, 3) == 0);
    if (roll < 18) begin
      r.operation = OP_CREATE;
      if ($urandom_range(0, 9) < 7) r.task_id = pick_slot(WANT_DEAD);
    end else if (roll < 32) begin
      r.operation = OP_SCHEDULE;
    end else if (roll < 46) begin
      r.operation = OP_BLOCK;
    end else if (roll < 64) begin
      r.operation = OP_UNBLOCK;
      if ($urandom_range(0, 9) < 7) r.task_id = pick_slot(WANT_PARKED);
    end else if (roll < 78) begin
      r.operation = OP_YIELD;
    end else if (roll < 95) begin
      r.operation = OP_EXIT;
      if ($urandom_range(0, 9) < 7) r.task_id = pick_slot(WANT_LIVE);
    end else begin
      r.operation = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end
    return r;
  endfunction

  // Removing a queued task walks both of its links, so until both were written its exit is sent as a schedule.
  function automatic req_t keep_links_defined(req_t r);
    if (r.operation == OP_EXIT && sb.status[r.task_id] == ST_READY &&
        !(sb.next_known[r.task_id] && sb.prev_known[r.task_id]))
      r.operation = OP_SCHEDULE;
    return r;
  endfunction

  task automatic send_item(input req_t r);
    req_t item;
    item = keep_links_defined(r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req <= item;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sb.note_item(item);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_idle(input logic [TID_W-1:0] slot_no);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= slot_no;
    @(posedge clk_i);
    while (cfg_ready !== 1'b1) @(posedge clk_i);
    sb.idle = slot_no;
    sb.idle_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("Timed out waiting for the scheduler.");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed sequence with the idle slot at its reset value of zero.
    send_item(mk(OP_SCHEDULE, 4'd0, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_BLOCK, 4'd0, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_YIELD, 4'd0, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_SPARE_A, 4'd9, KIND_BAD, 1'b1, 1'b1));
    send_item(mk(OP_SPARE_B, 4'd6, KIND_WAITING, 1'b0, 1'b1));
    send_item(mk(OP_UNBLOCK, 4'd5, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_EXIT, 4'd5, KIND_BLOCKED, 1'b1, 1'b0));
    send_item(mk(OP_CREATE, 4'd0, KIND_BLOCKED, 1'b0, 1'b1));
    send_item(mk(OP_CREATE, 4'd1, KIND_BLOCKED, 1'b0, 1'b1));
    send_item(mk(OP_CREATE, 4'd0, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_CREATE, 4'd15, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_CREATE, 4'd3, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_UNBLOCK, 4'd15, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_UNBLOCK, 4'd0, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_BLOCK, 4'd0, KIND_BAD, 1'b0, 1'b0));
    send_item(mk(OP_BLOCK, 4'd0, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_YIELD, 4'd0, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_BLOCK, 4'd0, KIND_WAITING, 1'b0, 1'b0));
    send_item(mk(OP_BLOCK, 4'd0, KIND_HANGING, 1'b0, 1'b0));
    send_item(mk(OP_UNBLOCK, 4'd3, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_EXIT, 4'd3, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_EXIT, 4'd0, KIND_BLOCKED, 1'b1, 1'b0));
    send_item(mk(OP_UNBLOCK, 4'd15, KIND_BLOCKED, 1'b0, 1'b0));
    send_item(mk(OP_SCHEDULE, 4'd0, KIND_BLOCKED, 1'b0, 1'b0));
    directed_items = sb.items;

    for (int p = 0; p < PHASES; p++) begin
      write_idle(p == PHASES - 1 ? TID_W'($urandom_range(0, NUM_TASKS - 1)) : idle_plan[p]);
      idle_pct = gap_plan[p];
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    wait_drained();
    $display("Covered %0d items (%0d directed) over %0d idle-slot settings.",
             sb.items, directed_items, sb.idle_writes);
    $display("Checked %0d results: %0d task switches, %0d with nothing runnable.",
             sb.checked, sb.switches, sb.no_run);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[round_robin_task_scheduler.f]
design/rrts_pkg.sv
design/rrts_ram.sv
design/rrts_dp.sv
design/rrts_ctrl.sv
design/round_robin_task_scheduler.sv
tb/tb.sv
